// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, reset masked
`define CHK_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");

// next-cycle implication, reset masked
`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");

`endif

// ===== sv/lpd_pkg.sv =====
`timescale 1ns / 1ps
package lpd_pkg;

  localparam int DEF_BLOCKS_PER_PACKET = 12;
  localparam int DEF_RETURNS_PER_BLOCK = 32;
  localparam int DEF_HEADER_BYTES      = 42;

  localparam logic [15:0] FLAG_WORD   = 16'hFFEE;
  localparam logic [10:0] FULL_FRAME  = 11'd1248;
  localparam logic [10:0] BODY_FRAME  = 11'd1206;
  localparam logic [10:0] STAMP_POS   = 11'd1200;
  localparam logic [10:0] STAMP_LAST  = 11'd1203;
  localparam logic [10:0] STAMP_END   = 11'd1204;
  localparam logic [6:0]  BLOCK_LAST  = 7'd99;
  localparam logic [16:0] AZ_FULL     = 17'd36000;
  localparam logic [11:0] LASER_NS    = 12'd2304;
  localparam logic [17:0] RECIP3      = 18'd174763;

  localparam logic [1:0] M_IDLE   = 2'd0;
  localparam logic [1:0] M_HEADER = 2'd1;
  localparam logic [1:0] M_BODY   = 2'd2;

  localparam logic [1:0] KIND_POINT = 2'd0;
  localparam logic [1:0] KIND_TRL   = 2'd1;
  localparam logic [1:0] KIND_ERR   = 2'd2;

  localparam logic [2:0] REG_DROP_EMPTY = 3'd0;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_of_frame;
    logic [10:0] frame_length;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  laser_index;
    logic [4:0]  firing_index;
    logic [15:0] azimuth_centideg;
    logic [15:0] distance_raw;
    logic [7:0]  intensity;
    logic [20:0] time_offset_ns;
    logic [31:0] packet_timestamp_us;
    logic        last;
  } out_t;

endpackage

// ===== sv/lpd_ram.sv =====
`timescale 1ns / 1ps
module lpd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// ===== sv/lpd_interp.sv =====
`timescale 1ns / 1ps
module lpd_interp
  import lpd_pkg::*;
(
  input  logic        clk,
  input  logic [15:0] gap,
  input  logic [5:0]  mult,
  input  logic [15:0] base,
  output logic [15:0] az
);
  logic [21:0] prod;
  logic [15:0] quot;
  logic [35:0] recip;
  logic [16:0] sum;

  // gap*mult/48 = (prod>>4)/3, divide by 3 through reciprocal
  assign recip = {18'd0, prod[21:4]} * {18'd0, RECIP3};

  always_ff @(posedge clk) begin
    prod <= gap * {16'd0, mult};
    quot <= recip[34:19];
  end

  assign sum = {1'b0, base} + {1'b0, quot};
  assign az  = (sum >= AZ_FULL) ? 16'(sum - AZ_FULL) : sum[15:0];
endmodule

// ===== sv/lidar_packet_point_decoder.sv =====
`timescale 1ns / 1ps
// channel   | valid      | stall      | payload
// bytes in  | byte_valid | byte_stall | byte_data (in_t)
// results   | res_valid  | res_stall  | res_data (out_t)
// A byte with no result does not stall the input. A block flush steps through
// each stored return with a return RAM read, the interpolation multiplies and
// a result push, then closes the request; trailer and error also close it.
// rst is synchronous; no clearing pass, return RAM is written before read.
// res_stall holds the flush at its push step only while the hold register is
// full; one result can wait in the output register while the next is formed.
module lidar_packet_point_decoder
  import lpd_pkg::*;
#(
  parameter int BLOCKS_PER_PACKET = DEF_BLOCKS_PER_PACKET,
  parameter int RETURNS_PER_BLOCK = DEF_RETURNS_PER_BLOCK,
  parameter int HEADER_BYTES      = DEF_HEADER_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  in_t         byte_data,
  output logic        res_valid,
  input  logic        res_stall,
  output out_t        res_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  `include "assert_macros.svh"

  localparam int AW = $clog2(RETURNS_PER_BLOCK);
  localparam logic [3:0] NBLK = 4'(BLOCKS_PER_PACKET);
  localparam logic [5:0] HDR  = 6'(HEADER_BYTES);
  localparam logic [AW-1:0] RLAST = AW'(RETURNS_PER_BLOCK - 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD   = 6'b000010,
    S_MUL  = 6'b000100,
    S_EMIT = 6'b001000,
    S_TRL  = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  state_t state, state_next;

  logic        drop_empty;
  logic [1:0]  mode, mode_next;
  logic [10:0] pos, pos_next;
  logic [5:0]  hdr_left, hdr_left_next;
  logic [3:0]  blk_num, blk_num_next;
  logic [15:0] pend_az, pend_az_next;
  logic        pend_v, pend_v_next;
  logic [15:0] prev_gap, prev_gap_next;
  logic [31:0] wa, wa_next;
  logic [6:0]  off, off_next;
  logic [3:0]  ob, ob_next;
  logic [4:0]  rcnt, rcnt_next;
  logic [1:0]  kcnt, kcnt_next;

  logic        ev_err, ev_flush, ev_trl;
  logic [3:0]  fblk_next;
  logic [15:0] fgap_next;
  logic        we;

  logic [AW-1:0] fr;
  logic [3:0]    fblk;
  logic [15:0]   fgap;
  logic [15:0]   fbase;
  logic          trl_pend;
  logic [23:0]   entry, rd_data;

  logic  hv, ov;
  out_t  hdata, odata;

  logic        accept, mv, push_ok, res_push;
  logic        half;
  logic [3:0]  laser;
  logic [4:0]  firing;
  logic [15:0] az_pt, az_raw, az_fix, gap_c;
  logic [9:0]  slot;
  logic        dropped;
  out_t        pt, trl, err_res, fin_res;

  assign pready     = 1'b1;
  assign prdata     = (paddr == REG_DROP_EMPTY) ? {31'd0, drop_empty} : 32'd0;
  assign byte_stall = (state != S_IDLE);
  assign accept     = byte_valid && !byte_stall;
  assign mv         = !ov || !res_stall;
  assign push_ok    = !hv || mv;
  assign res_valid  = ov;
  assign res_data   = odata;

  assign az_raw = {byte_data.data_byte, wa[7:0]};
  assign az_fix = ({1'b0, az_raw} >= AZ_FULL) ? 16'({1'b0, az_raw} - AZ_FULL) : az_raw;
  assign gap_c  = (az_fix >= pend_az) ? az_fix - pend_az
                                      : 16'({1'b0, az_fix} + AZ_FULL - {1'b0, pend_az});

  always_comb begin
    mode_next     = mode;
    pos_next      = pos;
    hdr_left_next = hdr_left;
    blk_num_next  = blk_num;
    pend_az_next  = pend_az;
    pend_v_next   = pend_v;
    prev_gap_next = prev_gap;
    wa_next       = wa;
    off_next      = off;
    ob_next       = ob;
    rcnt_next     = rcnt;
    kcnt_next     = kcnt;
    ev_err        = 1'b0;
    ev_flush      = 1'b0;
    ev_trl        = 1'b0;
    fblk_next     = blk_num;
    fgap_next     = prev_gap;
    we            = 1'b0;
    if (byte_data.first_of_frame) begin
      pos_next      = '0;
      off_next      = '0;
      ob_next       = '0;
      blk_num_next  = '0;
      pend_v_next   = 1'b0;
      prev_gap_next = '0;
      wa_next       = '0;
      if (byte_data.frame_length == FULL_FRAME) begin
        hdr_left_next = HDR;
        mode_next     = (HDR != 6'd0) ? M_HEADER : M_BODY;
      end else if (byte_data.frame_length == BODY_FRAME) begin
        hdr_left_next = '0;
        mode_next     = M_BODY;
      end else begin
        mode_next = M_IDLE;
      end
    end
    if (mode_next == M_HEADER) begin
      hdr_left_next = hdr_left_next - 6'd1;
      if (hdr_left_next == 6'd0) begin
        mode_next = M_BODY;
      end
    end else if (mode_next == M_BODY) begin
      if (pos_next < STAMP_POS) begin
        if (ob_next < NBLK) begin
          blk_num_next = ob_next;
          case (off_next)
            7'd0, 7'd2: begin
              wa_next = {24'd0, byte_data.data_byte};
            end
            7'd1: begin
              if ({wa[7:0], byte_data.data_byte} != FLAG_WORD) begin
                ev_err      = 1'b1;
                pend_v_next = 1'b0;
                mode_next   = M_IDLE;
              end
            end
            7'd3: begin
              if (pend_v) begin
                ev_flush      = 1'b1;
                fgap_next     = gap_c;
                fblk_next     = ob_next - 4'd1;
                prev_gap_next = gap_c;
              end
              pend_az_next = az_fix;
              pend_v_next  = 1'b1;
            end
            default: begin
              case (kcnt)
                2'd0: wa_next = {24'd0, byte_data.data_byte};
                2'd1: wa_next = {16'd0, byte_data.data_byte, wa[7:0]};
                default: we = 1'b1;
              endcase
            end
          endcase
        end
        if (off_next == 7'd3) begin
          rcnt_next = '0;
          kcnt_next = '0;
        end else if (off_next > 7'd3) begin
          if (kcnt == 2'd2) begin
            kcnt_next = '0;
            rcnt_next = rcnt + 5'd1;
          end else begin
            kcnt_next = kcnt + 2'd1;
          end
        end
        if (off_next == BLOCK_LAST) begin
          off_next = '0;
          ob_next  = ob_next + 4'd1;
        end else begin
          off_next = off_next + 7'd1;
        end
      end else if (pos_next < STAMP_END) begin
        case (pos_next[1:0])
          2'd0: wa_next = {24'd0, byte_data.data_byte};
          2'd1: wa_next = {16'd0, byte_data.data_byte, wa[7:0]};
          2'd2: wa_next = {8'd0, byte_data.data_byte, wa[15:0]};
          default: wa_next = {byte_data.data_byte, wa[23:0]};
        endcase
        if (pos_next == STAMP_LAST) begin
          ev_trl      = 1'b1;
          ev_flush    = pend_v;
          fblk_next   = blk_num;
          fgap_next   = prev_gap;
          pend_v_next = 1'b0;
        end
      end
      if (mode_next == M_BODY) begin
        pos_next = pos_next + 11'd1;
        if (pos_next >= BODY_FRAME) begin
          mode_next = M_IDLE;
        end
      end
    end
  end

  lpd_ram #(.WIDTH(24), .DEPTH(RETURNS_PER_BLOCK)) u_ram (
    .clk     (clk),
    .wr_en   (accept && we),
    .wr_addr (rcnt[AW-1:0]),
    .wr_data ({byte_data.data_byte, wa[15:0]}),
    .rd_addr (fr),
    .rd_data (rd_data)
  );

  assign half   = fr[AW-1];
  assign laser  = fr[3:0];
  assign firing = {fblk, 1'b0} + {4'd0, half};
  assign slot   = {1'b0, firing, 4'd0} + {2'b0, firing, 3'd0} + {6'd0, laser};

  lpd_interp u_interp (
    .clk  (clk),
    .gap  (fgap),
    .mult (half ? {2'd0, laser} + 6'd24 : {2'd0, laser}),
    .base (fbase),
    .az   (az_pt)
  );

  assign dropped  = drop_empty && (entry[15:0] == 16'd0);
  assign res_push = (state == S_EMIT && !dropped && push_ok) || (state == S_TRL && push_ok);

  always_comb begin
    pt                     = '0;
    pt.kind                = KIND_POINT;
    pt.laser_index         = laser;
    pt.firing_index        = firing;
    pt.azimuth_centideg    = az_pt;
    pt.distance_raw        = entry[15:0];
    pt.intensity           = entry[23:16];
    pt.time_offset_ns      = 21'({11'd0, slot} * {9'd0, LASER_NS});
    trl                    = '0;
    trl.kind               = KIND_TRL;
    trl.packet_timestamp_us = wa;
    err_res                = '0;
    err_res.kind           = KIND_ERR;
    err_res.firing_index   = {ob_next, 1'b0};
    fin_res                = hdata;
    fin_res.last           = 1'b1;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (ev_err) state_next = S_FIN;
          else if (ev_flush) state_next = S_RD;
          else if (ev_trl) state_next = S_TRL;
        end
      end
      S_RD:  state_next = S_MUL;
      S_MUL: state_next = S_EMIT;
      S_EMIT: begin
        if (dropped || push_ok) begin
          if (fr == RLAST) state_next = trl_pend ? S_TRL : S_FIN;
          else state_next = S_RD;
        end
      end
      S_TRL: if (push_ok) state_next = S_FIN;
      S_FIN: if (!hv || mv) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      drop_empty <= 1'b0;
      mode       <= M_IDLE;
      pos        <= '0;
      hdr_left   <= '0;
      blk_num    <= '0;
      pend_az    <= '0;
      pend_v     <= 1'b0;
      prev_gap   <= '0;
      wa         <= '0;
      off        <= '0;
      ob         <= '0;
      rcnt       <= '0;
      kcnt       <= '0;
      hv         <= 1'b0;
      ov         <= 1'b0;
      trl_pend   <= 1'b0;
      fr         <= '0;
    end else begin
      state <= state_next;
      if (psel && penable && pwrite && pready && paddr == REG_DROP_EMPTY) begin
        drop_empty <= pwdata[0];
      end
      if (accept) begin
        mode     <= mode_next;
        pos      <= pos_next;
        hdr_left <= hdr_left_next;
        blk_num  <= blk_num_next;
        pend_az  <= pend_az_next;
        pend_v   <= pend_v_next;
        prev_gap <= prev_gap_next;
        wa       <= wa_next;
        off      <= off_next;
        ob       <= ob_next;
        rcnt     <= rcnt_next;
        kcnt     <= kcnt_next;
        fr       <= '0;
        fblk     <= fblk_next;
        fgap     <= fgap_next;
        fbase    <= pend_az;
        trl_pend <= ev_trl;
        if (ev_err) begin
          hv    <= 1'b1;
          hdata <= err_res;
        end
      end
      if (state == S_MUL) begin
        entry <= rd_data;
      end
      if (state == S_EMIT && (dropped || push_ok)) begin
        fr <= fr + AW'(1);
      end
      if (res_push) begin
        hv    <= 1'b1;
        hdata <= (state == S_TRL) ? trl : pt;
      end
      if (state == S_FIN && hv && mv) begin
        hv <= 1'b0;
      end
      if ((res_push && hv) || (state == S_FIN && hv && mv)) begin
        ov    <= 1'b1;
        odata <= (state == S_FIN) ? fin_res : hdata;
      end else if (ov && !res_stall) begin
        ov <= 1'b0;
      end
    end
  end

  `CHK_IMPL(a_idle_no_held, state == S_IDLE, !hv)
  `CHK_IMPL(a_trl_last, res_valid && res_data.kind == KIND_TRL, res_data.last)
  `CHK_IMPL(a_wr_idle, accept && we, state == S_IDLE)
  `CHK_NEXT(a_err_fin, accept && ev_err, state == S_FIN && hv)
endmodule
